@@ rtl/core/hex_dump_text_parser_top_defines.svh @@
// assertion macros for the hex dump text parser
`ifndef HEX_DUMP_TEXT_PARSER_TOP_DEFINES_SVH
`define HEX_DUMP_TEXT_PARSER_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define HDTP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hdtp check failed");

// consequent checked in the cycle after the antecedent
`define HDTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hdtp check failed");

`endif

@@ rtl/core/hdtp_pkg.sv @@
// shared constants and character helpers for the hex dump text parser
`timescale 1ns / 1ps

package hdtp_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned DCNT_W    = 5;
  localparam int unsigned RCNT_W    = 4;
  localparam int unsigned BSEL_W    = 3;

  localparam logic [DCNT_W-1:0] MAX_DIGITS = 5'd16;

  localparam logic [CH_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ADDR = 1'b1;

  function automatic logic hex_valid(input logic [CH_W-1:0] c);
    logic ok;
    ok = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return ok;
  endfunction

  function automatic logic [3:0] hex_val(input logic [CH_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    case (c) inside
      [8'h30:8'h39]: v = c[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: v = c[3:0] + 4'd9;
      default:       v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic is_white(input logic [CH_W-1:0] c);
    logic w;
    w = (c inside {CHAR_SPACE, [8'h09:8'h0D]});
    return w;
  endfunction

endpackage

@@ rtl/core/hdtp_in_if.sv @@
// input character channel
`timescale 1ns / 1ps

interface hdtp_in_if import hdtp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

@@ rtl/core/hdtp_out_if.sv @@
// result channel
`timescale 1ns / 1ps

interface hdtp_out_if import hdtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_byte;
  logic [ADDR_W-1:0] target_address;
  logic              run_last;

  modport source (output valid, output kind, output data_byte, output target_address,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input target_address,
                  input run_last, output ready);
endinterface

@@ rtl/core/hex_dump_text_parser_top.sv @@
// hex dump text parser: line/token decode and result sequencer
//
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   ch, end_of_input
//  out_o     out  valid/ready   kind, data_byte, target_address, run_last
//  cfg       in   cfg_we_i      cfg_wdata_i (use_address)
//
// one character is decoded per cycle while no earlier result beats are pending;
// a character that closes a token loads a result register that hands out one
// beat per cycle while out_o is ready (up to 8 data bytes or one address), and
// the next character is taken in the cycle the last beat leaves.
// async active-low reset returns to line start with use_address cleared.
`timescale 1ns / 1ps

module hex_dump_text_parser_top import hdtp_pkg::*; #(
  parameter int unsigned LINE_CHARS = 511
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  hdtp_in_if.sink          in_i,
  hdtp_out_if.source       out_o
);

  localparam int unsigned POS_W = $clog2(LINE_CHARS + 1);

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_TOKEN,
    PH_ADDR_SKIP,
    PH_EXPECT,
    PH_SKIP,
    PH_STOP
  } phase_e;

  phase_e              phase_q, phase_d, ph_take;
  logic [ADDR_W-1:0]   tv_q, tv_d, tv_a;
  logic [DCNT_W-1:0]   dc_q, dc_d, dc_a, dc_inc;
  logic                first_q, first_d;
  logic [POS_W-1:0]    pos_q, pos_d, pos_inc;
  logic                after_cr_q, after_cr_d;
  logic                use_addr_q;

  logic [RCNT_W-1:0]   cnt_q;
  logic                kind_q;
  logic [ADDR_W-1:0]   val_q;

  logic                hex_ok, white, sep, nl, swallow, active;
  logic                end_take, flush, tok_end, line_end, is_addr;
  logic [3:0]          hex_d;
  logic [RCNT_W-1:0]   emit_cnt;
  logic [BSEL_W-1:0]   bsel;
  logic                in_fire, out_fire;

  // character decode and next state
  always_comb begin
    hex_ok   = hex_valid(in_i.ch);
    hex_d    = hex_val(in_i.ch);
    white    = is_white(in_i.ch);
    sep      = white || (in_i.ch == CHAR_DASH);
    nl       = (in_i.ch == CHAR_CR) || (in_i.ch == CHAR_LF);
    swallow  = after_cr_q && (in_i.ch == CHAR_LF);
    active   = !swallow && (phase_q != PH_STOP);
    ph_take  = phase_q;
    tv_a     = tv_q;
    dc_a     = dc_q;
    dc_inc   = (dc_q == MAX_DIGITS) ? MAX_DIGITS : dc_q + 5'd1;
    end_take = 1'b0;
    if (active) begin
      case (phase_q)
        PH_LINE_START: begin
          if (hex_ok) begin
            tv_a    = {{(ADDR_W-4){1'b0}}, hex_d};
            dc_a    = 5'd1;
            ph_take = PH_TOKEN;
          end else begin
            ph_take = PH_STOP;
          end
        end
        PH_TOKEN: begin
          if (hex_ok) begin
            tv_a = {tv_q[ADDR_W-5:0], hex_d};
            dc_a = dc_inc;
          end else begin
            end_take = 1'b1;
            ph_take  = PH_SKIP;
          end
        end
        PH_ADDR_SKIP, PH_EXPECT: begin
          if (hex_ok) begin
            tv_a    = {{(ADDR_W-4){1'b0}}, hex_d};
            dc_a    = 5'd1;
            ph_take = PH_TOKEN;
          end else if (!white || (phase_q == PH_EXPECT)) begin
            ph_take = PH_SKIP;
          end
        end
        default: ;
      endcase
    end

    is_addr = first_q && (dc_a > 5'd2);
    if (end_take && sep) begin
      ph_take = is_addr ? PH_ADDR_SKIP : PH_EXPECT;
    end

    pos_inc  = pos_q + POS_W'(1);
    line_end = (active && (nl || (pos_inc >= POS_W'(LINE_CHARS)))) || in_i.end_of_input;
    flush    = line_end && (ph_take == PH_TOKEN);
    tok_end  = end_take || flush;

    emit_cnt = '0;
    if (tok_end) begin
      emit_cnt = is_addr ? {{(RCNT_W-1){1'b0}}, use_addr_q} : RCNT_W'((dc_a + 5'd1) >> 1);
    end

    phase_d    = line_end ? ((ph_take == PH_STOP) ? PH_STOP : PH_LINE_START) : ph_take;
    tv_d       = (line_end || tok_end) ? '0 : tv_a;
    dc_d       = (line_end || tok_end) ? '0 : dc_a;
    first_d    = line_end ? 1'b1 : (tok_end ? 1'b0 : first_q);
    pos_d      = line_end ? '0 : (active ? pos_inc : pos_q);
    after_cr_d = !in_i.end_of_input && !swallow && (in_i.ch == CHAR_CR);
  end

  // handshakes
  assign in_i.ready = (cnt_q == '0) || ((cnt_q == RCNT_W'(1)) && out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // result beats, high byte first
  assign bsel                 = BSEL_W'(cnt_q - RCNT_W'(1));
  assign out_o.valid          = (cnt_q != '0);
  assign out_o.kind           = kind_q;
  assign out_o.data_byte      = (kind_q == KIND_ADDR) ? '0 : val_q[bsel*BYTE_W +: BYTE_W];
  assign out_o.target_address = (kind_q == KIND_ADDR) ? val_q : '0;
  assign out_o.run_last       = (cnt_q == RCNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LINE_START;
      tv_q       <= '0;
      dc_q       <= '0;
      first_q    <= 1'b1;
      pos_q      <= '0;
      after_cr_q <= 1'b0;
      use_addr_q <= 1'b0;
      cnt_q      <= '0;
      kind_q     <= KIND_DATA;
      val_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        use_addr_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q    <= phase_d;
        tv_q       <= tv_d;
        dc_q       <= dc_d;
        first_q    <= first_d;
        pos_q      <= pos_d;
        after_cr_q <= after_cr_d;
        cnt_q      <= emit_cnt;
        kind_q     <= is_addr;
        val_q      <= tv_a;
      end else if (out_fire) begin
        cnt_q <= cnt_q - RCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/hdtp_checker.sv @@
// port-level checks for the hex dump text parser, bound to the top level
`timescale 1ns / 1ps
`include "hex_dump_text_parser_top_defines.svh"

module hdtp_checker import hdtp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_kind_i,
  input logic [BYTE_W-1:0] out_data_byte_i,
  input logic [ADDR_W-1:0] out_target_address_i,
  input logic              out_run_last_i
);

  // stalled beat keeps its payload
  `HDTP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_byte_i) && $stable(out_target_address_i) && $stable(out_run_last_i))

  // a run keeps going until its last beat
  `HDTP_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_valid_i && out_ready_i && !out_run_last_i, out_valid_i)

  // no new character while a run is mid-way
  `HDTP_ASSERT(a_no_take_mid_run, clk_i, rst_ni, !(out_valid_i && !out_run_last_i && in_ready_i))

  // address beat stands alone with a zero byte field
  `HDTP_ASSERT(a_addr_alone, clk_i, rst_ni, !(out_valid_i && out_kind_i) || (out_run_last_i && (out_data_byte_i == '0)))

endmodule

bind hex_dump_text_parser_top hdtp_checker u_hdtp_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_kind_i           (out_o.kind),
  .out_data_byte_i      (out_o.data_byte),
  .out_target_address_i (out_o.target_address),
  .out_run_last_i       (out_o.run_last)
);

@@ tb/tb.sv @@
// self-checking testbench for the hex dump text parser: directed table, random text, drain
`timescale 1ns / 1ps

module tb;
  import hdtp_pkg::*;

  localparam int unsigned LINE_LEN     = 511;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 90;

  localparam logic [CH_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CH_W-1:0] CHAR_VT  = 8'h0B;
  localparam logic [CH_W-1:0] CHAR_FF  = 8'h0C;
  localparam logic [CH_W-1:0] CHAR_NUL = 8'h00;

  typedef enum logic [2:0] {
    PS_LINE_START, PS_TOKEN, PS_ADDR_GAP, PS_WANT_TOKEN, PS_IGNORE, PS_HALTED
  } parse_state_e;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;
  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] target_address;
    logic              run_last;
  } beat_t;

  typedef struct packed {
    row_kind_e       op;
    logic [CH_W-1:0] ch;
    logic            eoi;
    logic [9:0]      rep;
    check_e          chk;
    beat_t           beat;
  } stim_row_t;

  localparam beat_t NO_BEAT = '0;

  localparam int NUM_DIRECTED = 17;
  localparam int NUM_ROWS     = 24;

  stim_row_t stim_rows [NUM_ROWS] = '{
    '{ROW_CHAR, "1",       1'b0, 10'd3,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, " ",       1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, "a",       1'b0, 10'd1,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, CHAR_LF,   1'b0, 10'd1,  CHK_ONE,   '{KIND_DATA, 8'h0A, 64'd0, 1'b1}},
    '{ROW_CFG,  8'd1,      1'b0, 10'd1,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, "F",       1'b0, 10'd17, CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, CHAR_TAB,  1'b0, 10'd1,  CHK_ONE,
      '{KIND_ADDR, 8'h00, {ADDR_W{1'b1}}, 1'b1}},
    '{ROW_CHAR, " ",       1'b0, 10'd2,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, "0",       1'b0, 10'd1,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, CHAR_DASH, 1'b0, 10'd1,  CHK_ONE,   '{KIND_DATA, 8'h00, 64'd0, 1'b1}},
    '{ROW_CHAR, "f",       1'b0, 10'd1,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, "F",       1'b0, 10'd1,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, CHAR_NUL,  1'b0, 10'd1,  CHK_ONE,   '{KIND_DATA, 8'hFF, 64'd0, 1'b1}},
    '{ROW_CHAR, "~",       1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, CHAR_CR,   1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, CHAR_LF,   1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, "7",       1'b1, 10'd1,  CHK_ONE,   '{KIND_DATA, 8'h07, 64'd0, 1'b1}},
    // cut line, then the lone newline halts the parser for good
    '{ROW_CFG,  8'd1,      1'b0, 10'd1,  CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, "5",       1'b0, 10'(LINE_LEN), CHK_MODEL, NO_BEAT},
    '{ROW_CHAR, CHAR_LF,   1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, "A",       1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, " ",       1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, CHAR_NUL,  1'b0, 10'd1,  CHK_NONE,  NO_BEAT},
    '{ROW_CHAR, "B",       1'b1, 10'd1,  CHK_NONE,  NO_BEAT}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  hdtp_in_if  in_ch ();
  hdtp_out_if out_ch ();

  hex_dump_text_parser_top #(
    .LINE_CHARS (LINE_LEN)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  parse_state_e      pstate;
  logic [ADDR_W-1:0] tok_val;
  int unsigned       tok_digits;
  logic              tok_first;
  int unsigned       line_pos;
  logic              saw_cr;
  logic              use_addr;

  beat_t       expected_beats [$];
  beat_t       head_beat;
  int unsigned fail_count;
  int unsigned sent_items;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  function automatic int hex_digit(input logic [CH_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic white_char(input logic [CH_W-1:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic void open_token(input int d);
    tok_val    = ADDR_W'(d);
    tok_digits = 1;
    pstate     = PS_TOKEN;
  endfunction

  function automatic logic close_token();
    logic  is_addr;
    int    nbytes;
    beat_t b;
    is_addr = tok_first && tok_digits > 2;
    b = NO_BEAT;
    if (is_addr) begin
      if (use_addr) begin
        b.kind           = KIND_ADDR;
        b.target_address = tok_val;
        expected_beats.push_back(b);
      end
    end else begin
      nbytes = (tok_digits + 1) / 2;
      b.kind = KIND_DATA;
      for (int i = nbytes - 1; i >= 0; i--) begin
        b.data_byte = tok_val[8*i +: 8];
        expected_beats.push_back(b);
      end
    end
    tok_first  = 1'b0;
    tok_val    = '0;
    tok_digits = 0;
    return is_addr;
  endfunction

  function automatic void reset_parser();
    use_addr   = 1'b0;
    pstate     = PS_LINE_START;
    tok_val    = '0;
    tok_digits = 0;
    tok_first  = 1'b1;
    line_pos   = 0;
    saw_cr     = 1'b0;
  endfunction

  function automatic void decode_char(input logic [CH_W-1:0] c, input logic eoi);
    int unsigned n0;
    logic        line_end;
    logic        is_addr;
    int          d;
    beat_t       tail;
    n0 = expected_beats.size();
    line_end = 1'b0;
    if (saw_cr && c == CHAR_LF) begin
      saw_cr = 1'b0;
    end else begin
      saw_cr = (c == CHAR_CR);
      if (pstate != PS_HALTED) begin
        d = hex_digit(c);
        case (pstate)
          PS_LINE_START: begin
            if (d >= 0) open_token(d);
            else pstate = PS_HALTED;
          end
          PS_TOKEN: begin
            if (d >= 0) begin
              tok_val = {tok_val[ADDR_W-5:0], 4'(d)};
              if (tok_digits < MAX_DIGITS) tok_digits++;
            end else begin
              is_addr = close_token();
              if (white_char(c) || c == CHAR_DASH) begin
                pstate = is_addr ? PS_ADDR_GAP : PS_WANT_TOKEN;
              end else begin
                pstate = PS_IGNORE;
              end
            end
          end
          PS_ADDR_GAP: begin
            if (d >= 0) open_token(d);
            else if (!white_char(c)) pstate = PS_IGNORE;
          end
          PS_WANT_TOKEN: begin
            if (d >= 0) open_token(d);
            else pstate = PS_IGNORE;
          end
          default: ;
        endcase
        line_pos++;
        if (c == CHAR_CR || c == CHAR_LF || line_pos >= LINE_LEN) line_end = 1'b1;
      end
    end
    if (eoi) begin
      line_end = 1'b1;
      saw_cr   = 1'b0;
    end
    if (line_end) begin
      if (pstate == PS_TOKEN) is_addr = close_token();
      if (pstate != PS_HALTED) pstate = PS_LINE_START;
      line_pos   = 0;
      tok_first  = 1'b1;
      tok_val    = '0;
      tok_digits = 0;
    end
    if (expected_beats.size() > n0) begin
      tail = expected_beats.pop_back();
      tail.run_last = 1'b1;
      expected_beats.push_back(tail);
    end
  endfunction

  task automatic push_char(input logic [CH_W-1:0] c, input logic eoi,
                           input check_e chk = CHK_MODEL, input beat_t fixed_beat = NO_BEAT);
    int unsigned n0;
    beat_t       dropped;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.ch           <= c;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n0 = expected_beats.size();
    decode_char(c, eoi);
    if (chk != CHK_MODEL) begin
      while (expected_beats.size() > n0) dropped = expected_beats.pop_back();
      if (chk == CHK_ONE) expected_beats.push_back(fixed_beat);
    end
    sent_items++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_use_address(input logic value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    use_addr = value;
  endtask

  task automatic walk_rows(input int first, input int last);
    stim_row_t row;
    for (int i = first; i <= last; i++) begin
      row = stim_rows[i];
      if (row.op == ROW_CFG) begin
        write_use_address(row.ch[0]);
      end else begin
        for (int r = 0; r < row.rep; r++) begin
          push_char(row.ch, row.eoi && (r == row.rep - 1), row.chk, row.beat);
        end
      end
    end
  endtask

  function automatic logic [CH_W-1:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return CH_W'("0" + v);
    return CH_W'((upper ? "A" : "a") + v - 4'd10);
  endfunction

  function automatic logic [CH_W-1:0] pick_sep();
    case ($urandom_range(5))
      0, 1:    return CHAR_SPACE;
      2:       return CHAR_DASH;
      3:       return CHAR_TAB;
      4:       return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_junk();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(255)); while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  task automatic send_digits(input int count);
    for (int k = 0; k < count; k++) begin
      push_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
    end
  endtask

  task automatic send_line();
    int n_tok;
    case ($urandom_range(9))
      0, 1, 2, 3: send_digits($urandom_range(2, 1));
      9:          send_digits($urandom_range(20, 17));
      default:    send_digits($urandom_range(16, 3));
    endcase
    n_tok = $urandom_range(4);
    for (int t = 0; t < n_tok; t++) begin
      push_char(pick_sep(), 1'b0);
      if (t == 0 && $urandom_range(2) == 0) begin
        repeat ($urandom_range(3)) push_char(pick_sep(), 1'b0);
      end
      if ($urandom_range(11) == 0) push_char(pick_junk(), 1'b0);
      if ($urandom_range(7) == 0) send_digits($urandom_range(18, 5));
      else send_digits($urandom_range(4, 1));
    end
    if ($urandom_range(4) == 0) push_char(pick_sep(), 1'b0);
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(4, 1)) push_char(pick_junk(), 1'b0);
    end
    case ($urandom_range(5))
      0, 1: push_char(CHAR_LF, 1'b0);
      2:    push_char(CHAR_CR, $urandom_range(3) == 0);
      3: begin
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, $urandom_range(3) == 0);
      end
      4:       push_char(pick_junk(), 1'b1);
      default: push_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b1);
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent_items + count;
    while (sent_items < stop_at) send_line();
  endtask

  function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: beat with no expectation: expected none, actual kind %0d data %h addr %h",
                 $time, out_ch.kind, out_ch.data_byte, out_ch.target_address);
        fail_count++;
      end else begin
        head_beat = expected_beats.pop_front();
        check_field("kind", ADDR_W'(head_beat.kind), ADDR_W'(out_ch.kind));
        check_field("data_byte", ADDR_W'(head_beat.data_byte), ADDR_W'(out_ch.data_byte));
        check_field("target_address", head_beat.target_address, out_ch.target_address);
        check_field("run_last", ADDR_W'(head_beat.run_last), ADDR_W'(out_ch.run_last));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.ch           <= '0;
    in_ch.end_of_input <= 1'b0;
    fail_count  = 0;
    sent_items  = 0;
    tx_idle_pct = 30;
    rx_idle_pct = 61;
    reset_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    walk_rows(0, NUM_DIRECTED - 1);
    write_use_address(1'b0);
    run_random(RANDOM_ITEMS);

    tx_idle_pct = 61;
    rx_idle_pct = 30;
    write_use_address(1'b1);
    run_random(RANDOM_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_use_address(1'b0);
    run_random(RANDOM_ITEMS);

    walk_rows(NUM_DIRECTED, NUM_ROWS - 1);
    wait_idle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hdtp_pkg.sv
rtl/core/hdtp_in_if.sv
rtl/core/hdtp_out_if.sv
rtl/core/hex_dump_text_parser_top.sv
rtl/core/hdtp_checker.sv
tb/tb.sv
